[rtl/bcp_pkg.sv]
`default_nettype none

package bcp_pkg;

    // ASCII codes the parser reacts to
    localparam logic [7:0] CH_OPEN    = 8'h5B;  // '['
    localparam logic [7:0] CH_CLOSE   = 8'h5D;  // ']'
    localparam logic [7:0] CH_MINUS   = 8'h2D;  // '-'
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    // Request kinds on the input side
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TAKE = 1'b1;

    // Working magnitude saturates at 2^33
    localparam int          MAG_W   = 34;
    localparam int          PROD_W  = MAG_W + 4;
    localparam logic [MAG_W-1:0] MAG_CAP = 34'h2_0000_0000;

    localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VALUE_MIN = 32'h8000_0000;

    // One result item as produced by the parser core
    typedef struct packed {
        logic        command_ready;
        logic        taken;
        logic [7:0]  primary_letter;
        logic [7:0]  secondary_letter;
        logic [31:0] command_value;
    } bcp_result_t;

endpackage

`default_nettype wire

[rtl/bracket_command_parser.sv]
// Channel  Dir  tdata                                  tuser
// s_axis   in   [7:0] char_byte                        [0] action
// m_axis   out  [7:0] primary_letter,                  [0] command_ready,
//               [15:8] secondary_letter,               [1] taken
//               [47:16] command_value
//
// Every request gives exactly one result, which is registered first in the
// input register and then in the result register.
// Sustained rate is one request per cycle while m_axis does not stall; the
// parse update is a single combinational step between the two registers.
// rst_n clears the parser state, the held command and both valid flags.
// A stall on m_axis holds the result; s_axis keeps accepting until the
// input register is also full.
`default_nettype none

module bracket_command_parser
    import bcp_pkg::*;
#(
    parameter int LINE_CAPACITY   = 64,
    parameter int VALUE_CHARS_MAX = 10
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  wire logic        s_axis_tuser,   // [0] action

    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [47:0] m_axis_tdata,   // [7:0] primary, [15:8] secondary, [47:16] value
    output      logic [1:0]  m_axis_tuser    // [0] command_ready, [1] taken
);

    logic        in_valid_reg,  in_valid_next;
    logic        in_action_reg;
    logic [7:0]  in_char_reg;
    logic        out_valid_reg, out_valid_next;
    bcp_result_t out_reg;
    bcp_result_t core_result;
    logic        s_accept;
    logic        advance;

    // Handshake: input register moves on when the result register frees up
    assign advance        = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready  = !in_valid_reg || advance;
    assign s_accept       = s_axis_tvalid && s_axis_tready;
    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_action_reg <= s_axis_tuser;
            in_char_reg   <= s_axis_tdata;
        end
        if (advance)
            out_reg <= core_result;
    end

    bcp_core #(
        .LINE_CAPACITY   (LINE_CAPACITY),
        .VALUE_CHARS_MAX (VALUE_CHARS_MAX)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .action    (in_action_reg),
        .char_byte (in_char_reg),
        .result    (core_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.command_value, out_reg.secondary_letter,
                            out_reg.primary_letter};
    assign m_axis_tuser  = {out_reg.taken, out_reg.command_ready};

endmodule

`default_nettype wire

[rtl/bcp_core.sv]
`default_nettype none

module bcp_core
    import bcp_pkg::*;
#(
    parameter int LINE_CAPACITY   = 64,
    parameter int VALUE_CHARS_MAX = 10
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,       // item in the input register is processed
    input  wire logic        action,
    input  wire logic [7:0]  char_byte,
    output bcp_result_t      result      // result of the item being processed
);

    localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
    localparam int CNT_W = $clog2(VALUE_CHARS_MAX + 1);

    typedef enum logic [2:0] {
        PH_OPEN,
        PH_UPPER,
        PH_LOWER,
        PH_VALUE,
        PH_CLOSED,
        PH_BAD
    } phase_t;

    phase_t             phase_reg,     phase_next;
    logic [LEN_W-1:0]   len_reg,       len_next;
    logic [7:0]         w_primary_reg, w_primary_next;
    logic [7:0]         w_second_reg,  w_second_next;
    logic [MAG_W-1:0]   mag_reg,       mag_next;
    logic               neg_reg,       neg_next;
    logic [CNT_W-1:0]   chars_reg,     chars_next;
    logic [7:0]         h_primary_reg, h_primary_next;
    logic [7:0]         h_second_reg,  h_second_next;
    logic [31:0]        h_value_reg,   h_value_next;
    logic               h_valid_reg,   h_valid_next;

    logic               took;
    logic               is_digit, is_minus, value_ok;
    logic [PROD_W-1:0]  mag_prod;
    logic [LEN_W-1:0]   len_inc;
    logic [31:0]        latch_value;

    // Character classes and the decimal accumulate step
    assign is_digit = (char_byte >= CH_DIGIT_0) && (char_byte <= CH_DIGIT_9);
    assign is_minus = (char_byte == CH_MINUS) && (chars_reg == '0);
    assign value_ok = (is_digit || is_minus) && (chars_reg < CNT_W'(VALUE_CHARS_MAX));
    assign mag_prod = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1)
                    + PROD_W'(char_byte - CH_DIGIT_0);
    assign len_inc  = len_reg + LEN_W'(1);

    // Signed value with saturation for a closed line
    always_comb
    begin
        if (neg_reg)
        begin
            if (mag_reg >= MAG_W'(VALUE_MIN))
                latch_value = VALUE_MIN;
            else
                latch_value = 32'd0 - mag_reg[31:0];
        end
        else
        begin
            if (mag_reg > MAG_W'(VALUE_MAX))
                latch_value = VALUE_MAX;
            else
                latch_value = mag_reg[31:0];
        end
    end

    // Next state for one item
    always_comb
    begin
        phase_next     = phase_reg;
        len_next       = len_reg;
        w_primary_next = w_primary_reg;
        w_second_next  = w_second_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        chars_next     = chars_reg;
        h_primary_next = h_primary_reg;
        h_second_next  = h_second_reg;
        h_value_next   = h_value_reg;
        h_valid_next   = h_valid_reg;
        took           = 1'b0;

        if (action == ACT_TAKE)
        begin
            took         = h_valid_reg;
            h_valid_next = 1'b0;
        end
        else if (char_byte == CH_CR && !h_valid_reg)
        begin
            // End of line: latch a good command or clear the held one
            if (phase_reg == PH_CLOSED)
            begin
                h_primary_next = w_primary_reg;
                h_second_next  = w_second_reg;
                h_value_next   = latch_value;
                h_valid_next   = 1'b1;
            end
            else
            begin
                h_primary_next = 8'd0;
                h_second_next  = 8'd0;
                h_value_next   = 32'd0;
                h_valid_next   = 1'b0;
            end
            phase_next     = PH_OPEN;
            len_next       = '0;
            w_primary_next = 8'd0;
            w_second_next  = 8'd0;
            mag_next       = '0;
            neg_next       = 1'b0;
            chars_next     = '0;
        end
        else if (char_byte != CH_LF)
        begin
            case (phase_reg)
                PH_OPEN:
                begin
                    phase_next = (char_byte == CH_OPEN) ? PH_UPPER : PH_BAD;
                end
                PH_UPPER:
                begin
                    if (char_byte >= CH_UPPER_A && char_byte <= CH_UPPER_Z)
                    begin
                        w_primary_next = char_byte;
                        phase_next     = PH_LOWER;
                    end
                    else
                        phase_next = PH_BAD;
                end
                PH_LOWER:
                begin
                    if (char_byte >= CH_LOWER_A && char_byte <= CH_LOWER_Z)
                    begin
                        w_second_next = char_byte;
                        phase_next    = PH_VALUE;
                    end
                    else
                        phase_next = PH_BAD;
                end
                PH_VALUE:
                begin
                    if (value_ok)
                    begin
                        if (is_minus)
                            neg_next = 1'b1;
                        else if (mag_prod > PROD_W'(MAG_CAP))
                            mag_next = MAG_CAP;
                        else
                            mag_next = mag_prod[MAG_W-1:0];
                        chars_next = chars_reg + CNT_W'(1);
                    end
                    else if (char_byte == CH_CLOSE)
                        phase_next = PH_CLOSED;
                    else
                        phase_next = PH_BAD;
                end
                PH_CLOSED:
                begin
                    phase_next = PH_CLOSED;
                end
                default:
                begin
                    phase_next = PH_BAD;
                end
            endcase

            // Full line buffer restarts the line without latching
            len_next = len_inc;
            if (len_inc >= LEN_W'(LINE_CAPACITY))
            begin
                phase_next     = PH_OPEN;
                len_next       = '0;
                w_primary_next = 8'd0;
                w_second_next  = 8'd0;
                mag_next       = '0;
                neg_next       = 1'b0;
                chars_next     = '0;
            end
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OPEN;
            len_reg       <= '0;
            w_primary_reg <= 8'd0;
            w_second_reg  <= 8'd0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            chars_reg     <= '0;
            h_primary_reg <= 8'd0;
            h_second_reg  <= 8'd0;
            h_value_reg   <= 32'd0;
            h_valid_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            w_primary_reg <= w_primary_next;
            w_second_reg  <= w_second_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            chars_reg     <= chars_next;
            h_primary_reg <= h_primary_next;
            h_second_reg  <= h_second_next;
            h_value_reg   <= h_value_next;
            h_valid_reg   <= h_valid_next;
        end
    end

    // Result reflects the held command after this item
    assign result.command_ready    = h_valid_next;
    assign result.taken            = took;
    assign result.primary_letter   = h_primary_next;
    assign result.secondary_letter = h_second_next;
    assign result.command_value    = h_value_next;

endmodule

`default_nettype wire

[rtl/bcp_checker.sv]
`default_nettype none

module bcp_checker
    import bcp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // A stalled result stays offered and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result dropped or changed while stalled");

    // With no result waiting the input side always takes a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty result register");

    // A take that delivers a command leaves nothing pending
    a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
        else $error("command still pending after take");

    // A pending command always carries an upper-case primary letter
    a_primary_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[7:0] >= CH_UPPER_A && m_axis_tdata[7:0] <= CH_UPPER_Z)
        else $error("pending command with bad primary letter");

    // ... and a lower-case secondary letter
    a_secondary_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[15:8] >= CH_LOWER_A && m_axis_tdata[15:8] <= CH_LOWER_Z)
        else $error("pending command with bad secondary letter");

endmodule

bind bracket_command_parser bcp_checker u_bcp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
